### rtl/core/bda_pkg.sv
// ----------------------------------------------------------------------------
// Binary to decimal ASCII package
// Widths, digit counts and character codes shared by the converter modules.
// ----------------------------------------------------------------------------
package bda_pkg;

  localparam int WordW     = 32;
  localparam int NumDigits = 10;
  localparam int DigitW    = 4;
  localparam int DigitIdxW = $clog2(NumDigits);
  localparam int StepW     = $clog2(WordW);
  localparam int CharW     = 8;

  localparam logic [CharW-1:0] CharZero  = 8'h30;
  localparam logic [CharW-1:0] CharMinus = 8'h2D;

  localparam logic OpSigned   = 1'b0;
  localparam logic OpUnsigned = 1'b1;

  typedef logic [NumDigits-1:0][DigitW-1:0] bcd_t;

endpackage

### rtl/core/bda_dabble.sv
// ----------------------------------------------------------------------------
// Binary to decimal ASCII shift-and-adjust unit
// Converts a binary word to packed BCD one bit per cycle.
// ----------------------------------------------------------------------------
module bda_dabble (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     load,
  input  logic [bda_pkg::WordW-1:0] mag,
  output logic                     done,
  output bda_pkg::bcd_t            bcd
);
  import bda_pkg::*;

  logic [WordW-1:0] sh;
  logic [StepW-1:0] step;
  logic             run;
  bcd_t             adj;

  // Every digit of five or more is raised by three before the next shift.
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      adj[i] = (bcd[i] >= DigitW'(5)) ? bcd[i] + DigitW'(3) : bcd[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (load) begin
        run  <= 1'b1;
        step <= '0;
        sh   <= mag;
        bcd  <= '0;
      end else if (run) begin
        {bcd, sh} <= {adj[NumDigits-1:0], sh} << 1;
        step      <= step + StepW'(1);
        if (step == StepW'(WordW - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/core/binary_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// Binary to decimal ASCII converter
// Emits the decimal text of a 32-bit word, most significant digit first.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The word is turned
// into BCD by a shift-and-adjust loop, the digits are handed over, the leading
// digit is found, and then one character leaves per cycle on valid, with last
// set on the final one. Characters cannot be held off by the receiver, and busy
// drops on the cycle the last character is presented.
module binary_to_decimal_ascii (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [bda_pkg::WordW-1:0] number,
  input  logic                      operation,
  output logic                      valid,
  output logic [bda_pkg::CharW-1:0] character,
  output logic                      last
);
  import bda_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StConv,
    StFind,
    StSign,
    StDigit
  } state_t;

  state_t               state;
  logic                 neg;
  logic [WordW-1:0]     mag_next;
  logic                 neg_next;
  logic                 load;
  logic                 conv_done;
  bcd_t                 bcd;
  logic [DigitIdxW-1:0] idx;
  logic [DigitIdxW-1:0] idx_next;

  assign busy     = (state != StIdle);
  assign load     = start && !busy;
  assign neg_next = (operation == OpSigned) && number[WordW-1];
  assign mag_next = neg_next ? (~number + WordW'(1)) : number;

  always_comb begin
    idx_next = '0;
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd[i] != '0) begin
        idx_next = DigitIdxW'(i);
      end
    end
  end

  bda_dabble u_dabble (
    .clk  (clk),
    .rst  (rst),
    .load (load),
    .mag  (mag_next),
    .done (conv_done),
    .bcd  (bcd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      valid <= 1'b0;
      last  <= 1'b0;
    end else begin
      valid <= 1'b0;
      last  <= 1'b0;
      unique case (state)
        StIdle: begin
          if (load) begin
            neg   <= neg_next;
            state <= StConv;
          end
        end
        StConv: begin
          if (conv_done) begin
            state <= StFind;
          end
        end
        StFind: begin
          idx   <= idx_next;
          state <= neg ? StSign : StDigit;
        end
        StSign: begin
          valid     <= 1'b1;
          character <= CharMinus;
          state     <= StDigit;
        end
        StDigit: begin
          valid     <= 1'b1;
          character <= CharZero + CharW'(bcd[idx]);
          if (idx == '0) begin
            last  <= 1'b1;
            state <= StIdle;
          end else begin
            idx <= idx - DigitIdxW'(1);
          end
        end
        default: begin
          state <= StIdle;
        end
      endcase
    end
  end

  a_minus_not_last : assert property (@(posedge clk) disable iff (rst)
    (valid && character == CharMinus) |-> !last)
    else $error("minus sign flagged as last character");

  a_last_frees : assert property (@(posedge clk) disable iff (rst)
    (valid && last) |-> !busy)
    else $error("still busy after last character");

  a_accept_busy : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !valid))
    else $error("request not taken up");

  a_char_legal : assert property (@(posedge clk) disable iff (rst)
    valid |-> (character == CharMinus ||
               (character >= CharZero && character <= CharZero + CharW'(9))))
    else $error("illegal character");

endmodule

### dv/bda_text_checker.sv
// ----------------------------------------------------------------------------
// Decimal text checker
// Watches the request and character channels of the binary to decimal ASCII
// converter, works out the expected text of every accepted request and
// compares each character and its last flag against it, oldest first.
// ----------------------------------------------------------------------------
module bda_text_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      busy,
  input  logic [bda_pkg::WordW-1:0] number,
  input  logic                      operation,
  input  logic                      valid,
  input  logic [bda_pkg::CharW-1:0] character,
  input  logic                      last,
  output int                        mismatches,
  output int                        pending
);

  import bda_pkg::*;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             last;
  } text_char_t;

  text_char_t expected_text_q[$];

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR: %s", msg);
    mismatches++;
  endtask

  task automatic push_decimal_text(input logic [WordW-1:0] word, input logic op);
    logic             negative;
    logic [WordW-1:0] magnitude;
    logic [3:0]       digits[NumDigits];
    int               ndigits;
    text_char_t       entry;
    negative  = (op == OpSigned) && word[WordW-1];
    magnitude = negative ? (~word + 32'd1) : word;
    ndigits   = 0;
    do begin
      digits[ndigits] = 4'(magnitude % 32'd10);
      magnitude       = magnitude / 32'd10;
      ndigits++;
    end while (magnitude != 0);
    if (negative) begin
      entry.ch   = CharMinus;
      entry.last = 1'b0;
      expected_text_q.push_back(entry);
    end
    for (int k = ndigits - 1; k >= 0; k--) begin
      entry.ch   = CharZero + CharW'(digits[k]);
      entry.last = (k == 0);
      expected_text_q.push_back(entry);
    end
  endtask

  always @(posedge clk) begin
    text_char_t want;
    if (!rst) begin
      if (valid) begin
        if (expected_text_q.size() == 0) begin
          report_mismatch($sformatf("unexpected character 8'h%02h last=%0b",
                                    character, last));
        end else begin
          want = expected_text_q.pop_front();
          if (character !== want.ch) begin
            report_mismatch($sformatf("character 8'h%02h, expected 8'h%02h",
                                      character, want.ch));
          end
          if (last !== want.last) begin
            report_mismatch($sformatf("last %0b on character 8'h%02h, expected %0b",
                                      last, want.ch, want.last));
          end
        end
      end
      if (start && !busy) begin
        push_decimal_text(number, operation);
      end
      pending <= expected_text_q.size();
    end
  end

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// Binary to decimal ASCII converter testbench
// Drives directed boundary words and random words in both modes through the
// converter under several sender idle rates and lets the checker compare the
// emitted text.
// ----------------------------------------------------------------------------
module testbench;

  import bda_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 60;
  localparam int PhaseItems  = 95;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             start     = 1'b0;
  logic [WordW-1:0] number    = '0;
  logic             operation = OpSigned;
  logic             busy;
  logic             valid;
  logic [CharW-1:0] character;
  logic             last;
  int               mismatches;
  int               pending;
  int               cycles    = 0;

  always #4 clk = ~clk;

  binary_to_decimal_ascii u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .number    (number),
    .operation (operation),
    .valid     (valid),
    .character (character),
    .last      (last)
  );

  bda_text_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .number     (number),
    .operation  (operation),
    .valid      (valid),
    .character  (character),
    .last       (last),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("binary_to_decimal_ascii regression: fail");
      $finish;
    end
  end

  // Holds the request on the ports until the converter takes it.
  task automatic send_request(input logic [WordW-1:0] word, input logic op);
    start     <= 1'b1;
    number    <= word;
    operation <= op;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic [WordW-1:0] random_word();
    logic [WordW-1:0] power;
    logic [WordW-1:0] word;
    power = 32'd1;
    case ($urandom_range(0, 4))
      0: word = $urandom;
      1: word = $urandom >> $urandom_range(0, 31);
      2: begin
        repeat ($urandom_range(0, 9)) power = power * 32'd10;
        word = power + WordW'($urandom_range(0, 2)) - 32'd1;
        if ($urandom_range(0, 1)) word = ~word + 32'd1;
      end
      3: word = ~WordW'($urandom_range(0, 1000)) + 32'd1;
      default: begin
        case ($urandom_range(0, 3))
          0: word = 32'h0000_0000;
          1: word = 32'h7FFF_FFFF;
          2: word = 32'h8000_0000;
          default: word = 32'hFFFF_FFFF;
        endcase
      end
    endcase
    return word;
  endfunction

  initial begin
    logic [WordW-1:0] directed_words[12];
    int               idle_pct[3];
    logic [WordW-1:0] word;
    logic             op;
    directed_words = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100,
                       32'd999999999, 32'd1000000000, 32'h7FFF_FFFF,
                       32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFF6};
    idle_pct = '{0, 87, 36};

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_words[i]) begin
      send_request(directed_words[i], OpSigned);
      send_request(directed_words[i], OpUnsigned);
    end

    foreach (idle_pct[p]) begin
      for (int n = 0; n < PhaseItems; n++) begin
        if ($urandom_range(0, 99) < idle_pct[p]) begin
          start <= 1'b0;
          do @(posedge clk); while ($urandom_range(0, 99) < idle_pct[p]);
        end
        word = random_word();
        op   = $urandom_range(0, 1) ? OpUnsigned : OpSigned;
        send_request(word, op);
      end
    end
    start <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("binary_to_decimal_ascii regression: pass");
    end else begin
      $display("binary_to_decimal_ascii regression: fail");
    end
    $finish;
  end

endmodule
